// File: hdl/lr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lr_pkg
// Shared constants for the line rasterizer: field widths, register map,
// request kinds and reset values.
// ----------------------------------------------------------------------------
package lr_pkg;

  // coordinate width default and fixed field widths
  localparam int COORD_BITS_DEF = 13;
  localparam int DIM_BITS       = 13;
  localparam int COLOR_BITS     = 16;

  // configuration port
  localparam int APB_DATA_BITS = 32;
  localparam int APB_ADDR_BITS = 3;

  // register indexes (byte address is 4 * index)
  localparam logic REG_SCREEN_WIDTH  = 1'b0;
  localparam logic REG_SCREEN_HEIGHT = 1'b1;

  localparam logic [DIM_BITS-1:0] SCREEN_WIDTH_RESET  = DIM_BITS'(128);
  localparam logic [DIM_BITS-1:0] SCREEN_HEIGHT_RESET = DIM_BITS'(128);

  // request kinds carried on the slave tuser
  localparam logic REQ_START = 1'b0;
  localparam logic REQ_STEP  = 1'b1;

endpackage : lr_pkg
`default_nettype wire

// File: hdl/line_rasterizer_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// line_rasterizer_top
// Bresenham line rasterizer: a start request loads a line; a step request on
// a busy line emits the current pixel with on-screen/last flags, then advances.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Handshake               Contents
// s_*       in   s_tvalid / s_tready     tuser: request kind; tdata: endpoints,
//                                        color
// m_*       out  m_tvalid / m_tready     tdata: pixel x, y, color;
//                                        tuser: on screen; tlast: last pixel
// APB       in   psel & penable & pwrite screen_width (0x0), screen_height (0x4)
//
// One request is accepted per clock unless a step waits behind a stalled
// master. A request is held in the input register, and its pixel in the
// output register. The line state (position, error term, pixel count)
// updates in a single add/compare step as a request leaves the input
// register. A stalled master holds its pixel and the waiting step; a step
// that yields no pixel never waits. Reset is synchronous; after it the block
// is idle with a 128 x 128 screen.
//
module line_rasterizer_top #(
  parameter int COORD_BITS = lr_pkg::COORD_BITS_DEF,
  localparam int S_DATA_BITS = ((4 * COORD_BITS + lr_pkg::COLOR_BITS + 7) / 8) * 8,
  localparam int M_DATA_BITS = ((2 * COORD_BITS + lr_pkg::COLOR_BITS + 7) / 8) * 8
) (
  input  wire                               clk,
  input  wire                               rst,
  // request stream
  input  wire                               s_tvalid,
  output logic                              s_tready,
  // s_tdata, low bit up: start_x, start_y, end_x, end_y, line_color, zero pad
  input  wire  [S_DATA_BITS-1:0]            s_tdata,
  // s_tuser: req_type
  input  wire  [0:0]                        s_tuser,
  // pixel stream
  output logic                              m_tvalid,
  input  wire                               m_tready,
  // m_tdata, low bit up: pixel_x, pixel_y, pixel_color, zero pad
  output logic [M_DATA_BITS-1:0]            m_tdata,
  // m_tuser: on_screen
  output logic [0:0]                        m_tuser,
  output logic                              m_tlast,
  // configuration
  input  wire                               psel,
  input  wire                               penable,
  input  wire                               pwrite,
  input  wire  [lr_pkg::APB_ADDR_BITS-1:0]  paddr,
  input  wire  [lr_pkg::APB_DATA_BITS-1:0]  pwdata,
  output logic [lr_pkg::APB_DATA_BITS-1:0]  prdata,
  output logic                              pready
);

  localparam int CB  = COORD_BITS;
  localparam int EB  = COORD_BITS + 1;
  localparam int DB  = lr_pkg::DIM_BITS;
  localparam int KB  = lr_pkg::COLOR_BITS;
  // compare width for the on-screen test
  localparam int CMP = (CB > DB) ? CB : DB;

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [DB-1:0] screen_width;
  logic [DB-1:0] screen_height;
  logic          cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= lr_pkg::SCREEN_WIDTH_RESET;
      screen_height <= lr_pkg::SCREEN_HEIGHT_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == lr_pkg::REG_SCREEN_WIDTH) begin
        screen_width <= pwdata[DB-1:0];
      end else begin
        screen_height <= pwdata[DB-1:0];
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == lr_pkg::REG_SCREEN_WIDTH) begin
      prdata[DB-1:0] = screen_width;
    end else begin
      prdata[DB-1:0] = screen_height;
    end
  end

  // --------------------------------------------------------------------------
  // input register
  // --------------------------------------------------------------------------
  logic                 in_vld;
  logic                 in_kind;
  logic signed [CB-1:0] in_x0;
  logic signed [CB-1:0] in_y0;
  logic signed [CB-1:0] in_x1;
  logic signed [CB-1:0] in_y1;
  logic [KB-1:0]        in_color;
  logic                 advance;
  logic                 emit;

  assign s_tready = ~in_vld | advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (s_tready) begin
      in_vld <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_kind  <= s_tuser[0];
      in_x0    <= s_tdata[CB-1:0];
      in_y0    <= s_tdata[2*CB-1:CB];
      in_x1    <= s_tdata[3*CB-1:2*CB];
      in_y1    <= s_tdata[4*CB-1:3*CB];
      in_color <= s_tdata[4*CB+KB-1:4*CB];
    end
  end

  // --------------------------------------------------------------------------
  // line state
  // --------------------------------------------------------------------------
  logic signed [CB-1:0] cur_x;
  logic signed [CB-1:0] cur_y;
  logic [EB-1:0]        error_acc;
  logic [CB-1:0]        major_delta;
  logic [CB-1:0]        minor_delta;
  logic [CB-1:0]        pixels_left;
  logic                 x_is_major;
  logic                 x_negative;
  logic                 y_negative;
  logic [KB-1:0]        draw_color;
  logic                 line_busy;

  // start: absolute deltas in one extra bit, then truncate
  logic signed [CB:0] dx_raw;
  logic signed [CB:0] dy_raw;
  logic               x_neg_new;
  logic               y_neg_new;
  logic [CB-1:0]      dx_abs;
  logic [CB-1:0]      dy_abs;
  logic               x_major_new;
  logic [CB-1:0]      major_new;
  logic [CB-1:0]      minor_new;

  always_comb begin
    dx_raw      = {in_x1[CB-1], in_x1} - {in_x0[CB-1], in_x0};
    dy_raw      = {in_y1[CB-1], in_y1} - {in_y0[CB-1], in_y0};
    x_neg_new   = in_x1 < in_x0;
    y_neg_new   = in_y1 < in_y0;
    dx_abs      = x_neg_new ? CB'(-dx_raw) : dx_raw[CB-1:0];
    dy_abs      = y_neg_new ? CB'(-dy_raw) : dy_raw[CB-1:0];
    x_major_new = dx_abs >= dy_abs;
    major_new   = x_major_new ? dx_abs : dy_abs;
    minor_new   = x_major_new ? dy_abs : dx_abs;
  end

  // step: error term and next position
  logic [EB-1:0]        err_sum;
  logic                 minor_step;
  logic [EB-1:0]        err_next;
  logic signed [CB-1:0] x_inc;
  logic signed [CB-1:0] y_inc;
  logic signed [CB-1:0] cur_x_next;
  logic signed [CB-1:0] cur_y_next;
  logic                 last;
  logic                 on_scr;
  logic [CMP-1:0]       x_ext;
  logic [CMP-1:0]       y_ext;

  always_comb begin
    err_sum    = error_acc + {1'b0, minor_delta};
    minor_step = err_sum >= {1'b0, major_delta};
    err_next   = minor_step ? (err_sum - {1'b0, major_delta}) : err_sum;
    x_inc      = x_negative ? '1 : CB'(1);
    y_inc      = y_negative ? '1 : CB'(1);
    cur_x_next = (x_is_major || minor_step) ? (cur_x + x_inc) : cur_x;
    cur_y_next = (!x_is_major || minor_step) ? (cur_y + y_inc) : cur_y;
    last       = pixels_left == '0;
    x_ext      = CMP'($unsigned(cur_x));
    y_ext      = CMP'($unsigned(cur_y));
    on_scr     = !cur_x[CB-1] && !cur_y[CB-1] &&
                 (x_ext < CMP'(screen_width)) && (y_ext < CMP'(screen_height));
  end

  // a step while busy yields a pixel; anything else drains at once
  assign emit    = in_vld && (in_kind == lr_pkg::REQ_STEP) && line_busy;
  assign advance = in_vld && (!emit || !m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x       <= '0;
      cur_y       <= '0;
      error_acc   <= '0;
      major_delta <= '0;
      minor_delta <= '0;
      pixels_left <= '0;
      x_is_major  <= 1'b0;
      x_negative  <= 1'b0;
      y_negative  <= 1'b0;
      draw_color  <= '0;
      line_busy   <= 1'b0;
    end else if (advance) begin
      if (in_kind == lr_pkg::REQ_START) begin
        // load a new line, abandoning any in progress
        cur_x       <= in_x0;
        cur_y       <= in_y0;
        error_acc   <= EB'(major_new >> 1);
        major_delta <= major_new;
        minor_delta <= minor_new;
        pixels_left <= major_new;
        x_is_major  <= x_major_new;
        x_negative  <= x_neg_new;
        y_negative  <= y_neg_new;
        draw_color  <= in_color;
        line_busy   <= 1'b1;
      end else if (emit) begin
        if (last) begin
          line_busy <= 1'b0;
        end else begin
          cur_x       <= cur_x_next;
          cur_y       <= cur_y_next;
          error_acc   <= err_next;
          pixels_left <= pixels_left - CB'(1);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance && emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      m_tdata    <= M_DATA_BITS'({draw_color, cur_y, cur_x});
      m_tuser[0] <= on_scr;
      m_tlast    <= last;
    end
  end

endmodule : line_rasterizer_top
`default_nettype wire
